FILE: design/sqch_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the square-wave sound channel.
package sqch_pkg;

   typedef enum logic [2:0] {
      KIND_READ     = 3'd0,
      KIND_WRITE    = 3'd1,
      KIND_FREQ     = 3'd2,
      KIND_LENGTH   = 3'd3,
      KIND_ENVELOPE = 3'd4,
      KIND_CLEAR    = 3'd5
   } kind_type;

   localparam logic [15:0] ADDR_DUTY = 16'hFF16;
   localparam logic [15:0] ADDR_ENV  = 16'hFF17;
   localparam logic [15:0] ADDR_PLOW = 16'hFF18;
   localparam logic [15:0] ADDR_CTRL = 16'hFF19;

   localparam logic [7:0]  DUTY_READ_MASK = 8'h3F;
   localparam logic [7:0]  CTRL_READ_MASK = 8'hBF;
   localparam logic [7:0]  OPEN_BUS       = 8'hFF;
   localparam logic [31:0] DUTY_PATTERNS_RESET = 32'h7EE18180;
   localparam logic [6:0]  LENGTH_FULL    = 7'd64;
   localparam logic [11:0] PERIOD_SPAN    = 12'd2048;
   localparam logic [3:0]  VOLUME_MAX     = 4'd15;

   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] address;
      logic [7:0]  write_data;
   } item_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic [3:0] sample_level;
      logic       channel_on;
   } result_type;

endpackage

FILE: design/sqch_channel.sv
`timescale 1ns / 1ps
// Channel state registers and the single-pass update for one request.
module sqch_channel (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  sqch_pkg::item_type  item,
   input  logic [31:0]         duty_patterns,
   output sqch_pkg::result_type result
);
   import sqch_pkg::*;

   logic [7:0]  duty_length_ff, duty_length_in;
   logic [7:0]  envelope_ff, envelope_in;
   logic [7:0]  period_low_ff, period_low_in;
   logic [7:0]  control_ff, control_in;
   logic        active_ff, active_in;
   logic [6:0]  length_count_ff, length_count_in;
   logic [2:0]  envelope_count_ff, envelope_count_in;
   logic [3:0]  volume_ff, volume_in;
   logic [10:0] period_ff, period_in;
   logic [13:0] freq_timer_ff, freq_timer_in;
   logic [2:0]  duty_position_ff, duty_position_in;

   logic [10:0] trig_period;
   logic [11:0] span;
   logic [13:0] reload_cur;
   logic [13:0] reload_trig;
   logic [13:0] timer_dec;
   logic [2:0]  env_dec;
   logic [6:0]  len_dec;
   logic [7:0]  read_data;
   logic [4:0]  pattern_bit;

   always_comb begin
      trig_period = {item.write_data[2:0], period_low_ff};
      span        = PERIOD_SPAN - {1'b0, period_ff};
      reload_cur  = {span, 2'b00};
      span        = PERIOD_SPAN - {1'b0, trig_period};
      reload_trig = {span, 2'b00};
      timer_dec   = freq_timer_ff - 14'd1;
      env_dec     = envelope_count_ff - 3'd1;
      len_dec     = length_count_ff - 7'd1;
   end

   always_comb begin
      duty_length_in    = duty_length_ff;
      envelope_in       = envelope_ff;
      period_low_in     = period_low_ff;
      control_in        = control_ff;
      active_in         = active_ff;
      length_count_in   = length_count_ff;
      envelope_count_in = envelope_count_ff;
      volume_in         = volume_ff;
      period_in         = period_ff;
      freq_timer_in     = freq_timer_ff;
      duty_position_in  = duty_position_ff;
      read_data         = OPEN_BUS;

      case (kind_type'(item.kind))
         KIND_READ: begin
            if (item.address == ADDR_DUTY) begin
               read_data = duty_length_ff | DUTY_READ_MASK;
            end else if (item.address == ADDR_ENV) begin
               read_data = envelope_ff;
            end else if (item.address == ADDR_CTRL) begin
               read_data = control_ff | CTRL_READ_MASK;
            end
         end
         KIND_WRITE: begin
            if (item.address == ADDR_DUTY) begin
               duty_length_in  = item.write_data;
               length_count_in = LENGTH_FULL - {1'b0, item.write_data[5:0]};
            end else if (item.address == ADDR_ENV) begin
               envelope_in = item.write_data;
               if (item.write_data[7:3] == 5'd0) begin
                  active_in = 1'b0;
               end
            end else if (item.address == ADDR_PLOW) begin
               period_low_in = item.write_data;
            end else if (item.address == ADDR_CTRL) begin
               control_in = item.write_data;
               if (item.write_data[7]) begin
                  // trigger: restart the counters from the registers; the length counter only if it is zero
                  if (envelope_ff[7:3] != 5'd0) begin
                     active_in = 1'b1;
                  end
                  if (length_count_ff == 7'd0) begin
                     length_count_in = LENGTH_FULL;
                  end
                  envelope_count_in = envelope_ff[2:0];
                  volume_in         = envelope_ff[7:4];
                  period_in         = trig_period;
                  freq_timer_in     = reload_trig;
                  duty_position_in  = 3'd0;
               end
            end
         end
         KIND_FREQ: begin
            if (freq_timer_ff != 14'd0) begin
               freq_timer_in = timer_dec;
               if (timer_dec == 14'd0) begin
                  freq_timer_in    = reload_cur;
                  duty_position_in = duty_position_ff + 3'd1;
               end
            end
         end
         KIND_LENGTH: begin
            if (control_ff[6] && length_count_ff != 7'd0) begin
               length_count_in = len_dec;
               if (len_dec == 7'd0) begin
                  active_in = 1'b0;
               end
            end
         end
         KIND_ENVELOPE: begin
            if (envelope_ff[2:0] != 3'd0 && envelope_count_ff != 3'd0) begin
               envelope_count_in = env_dec;
               if (env_dec == 3'd0) begin
                  envelope_count_in = envelope_ff[2:0];
                  if (envelope_ff[3]) begin
                     if (volume_ff < VOLUME_MAX) begin
                        volume_in = volume_ff + 4'd1;
                     end
                  end else if (volume_ff != 4'd0) begin
                     volume_in = volume_ff - 4'd1;
                  end
               end
            end
         end
         KIND_CLEAR: begin
            duty_length_in    = 8'd0;
            envelope_in       = 8'd0;
            period_low_in     = 8'd0;
            control_in        = 8'd0;
            active_in         = 1'b0;
            length_count_in   = 7'd0;
            envelope_count_in = 3'd0;
            volume_in         = 4'd0;
            period_in         = 11'd0;
            freq_timer_in     = 14'd0;
            duty_position_in  = 3'd0;
         end
         default: begin
         end
      endcase

      pattern_bit         = {duty_length_in[7:6], duty_position_in};
      result.read_data    = read_data;
      result.channel_on   = active_in;
      result.sample_level = 4'd0;
      if (active_in && envelope_in[7:3] != 5'd0 && duty_patterns[pattern_bit]) begin
         result.sample_level = volume_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         duty_length_ff    <= 8'd0;
         envelope_ff       <= 8'd0;
         period_low_ff     <= 8'd0;
         control_ff        <= 8'd0;
         active_ff         <= 1'b0;
         length_count_ff   <= 7'd0;
         envelope_count_ff <= 3'd0;
         volume_ff         <= 4'd0;
         period_ff         <= 11'd0;
         freq_timer_ff     <= 14'd0;
         duty_position_ff  <= 3'd0;
      end else if (step) begin
         duty_length_ff    <= duty_length_in;
         envelope_ff       <= envelope_in;
         period_low_ff     <= period_low_in;
         control_ff        <= control_in;
         active_ff         <= active_in;
         length_count_ff   <= length_count_in;
         envelope_count_ff <= envelope_count_in;
         volume_ff         <= volume_in;
         period_ff         <= period_in;
         freq_timer_ff     <= freq_timer_in;
         duty_position_ff  <= duty_position_in;
      end
   end

endmodule

FILE: design/square_wave_sound_channel_top.sv
`timescale 1ns / 1ps
// Top level of the square-wave sound channel: request and response registers.
//
//   channel   ports                                          direction
//   req       req_valid req_stall req_type req_address          in
//             req_write_data
//   rsp       rsp_valid rsp_stall rsp_read_data                 out
//             rsp_sample_level rsp_channel_on
//   csr       csr_wr_en csr_wr_data (duty patterns word)        in
//
// One request per clock while the response side does not stall: a transfer
// lands in the request register, is applied to the channel state as it moves
// on into the response register, and a new request is taken in that same move.
// Reset clears every channel register and loads the standard duty patterns.
// While the response register holds an untaken result, the request register
// still empties into it as soon as the result is taken; req_stall rises only
// when both registers are full and the response side stalls.
module square_wave_sound_channel_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_type,
   input  logic [15:0] req_address,
   input  logic [7:0]  req_write_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_read_data,
   output logic [3:0]  rsp_sample_level,
   output logic        rsp_channel_on,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);
   import sqch_pkg::*;

   logic        in_valid_ff, in_valid_in;
   item_type    item_ff;
   logic        out_valid_ff, out_valid_in;
   result_type  result_ff;
   result_type  result_next;
   logic [31:0] duty_patterns_ff;
   logic        accept;
   logic        advance;

   // advance the held request when the response register is free or draining
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         out_valid_ff     <= 1'b0;
         duty_patterns_ff <= DUTY_PATTERNS_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_wr_en) begin
            duty_patterns_ff <= csr_wr_data;
         end
      end
   end

   // payload registers: hold the request and the result until they move on
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.kind       <= req_type;
         item_ff.address    <= req_address;
         item_ff.write_data <= req_write_data;
      end
      if (advance) begin
         result_ff <= result_next;
      end
   end

   sqch_channel u_channel (
      .clock         (clock),
      .reset         (reset),
      .step          (advance),
      .item          (item_ff),
      .duty_patterns (duty_patterns_ff),
      .result        (result_next)
   );

   assign rsp_valid        = out_valid_ff;
   assign rsp_read_data    = result_ff.read_data;
   assign rsp_sample_level = result_ff.sample_level;
   assign rsp_channel_on   = result_ff.channel_on;

endmodule

FILE: tb/sv/square_wave_sound_channel_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the square-wave sound channel top level.
module square_wave_sound_channel_top_tb;
   import sqch_pkg::*;

   // Request codes beyond the six defined kinds: the block must ignore them.
   localparam logic [2:0] KIND_SPARE_A = 3'd6;
   localparam logic [2:0] KIND_SPARE_B = 3'd7;

   localparam int DIRECTED_COUNT = 25;
   localparam int PHASE_COUNT    = 6;
   localparam int PHASE_ITEMS    = 200;

   // One row of the directed table. Where 'fixed' is set, the expected
   // result is the one typed into the row; otherwise the predictor decides.
   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] address;
      logic [7:0]  write_data;
      logic        fixed;
      logic [7:0]  read_data;
      logic [3:0]  sample_level;
      logic        channel_on;
   } step_row_type;

   // Every input of the block is driven to a known value from time zero.
   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_stall;
   logic [2:0]  req_type       = 3'd0;
   logic [15:0] req_address    = 16'd0;
   logic [7:0]  req_write_data = 8'd0;
   logic        rsp_valid;
   logic        rsp_stall      = 1'b1;
   logic [7:0]  rsp_read_data;
   logic [3:0]  rsp_sample_level;
   logic        rsp_channel_on;
   logic        csr_wr_en      = 1'b0;
   logic [31:0] csr_wr_data    = 32'd0;

   // Shadow copy of the channel, advanced once per request transfer.
   logic [31:0] duty_word;
   logic [7:0]  duty_len_q;
   logic [7:0]  env_q;
   logic [7:0]  plow_q;
   logic [7:0]  ctrl_q;
   logic        ch_active;
   logic [6:0]  len_left;
   logic [2:0]  env_left;
   logic [3:0]  volume;
   logic [10:0] period;
   logic [13:0] tone_timer;
   logic [2:0]  wave_pos;

   result_type  pending_results [$];
   int unsigned error_count  = 0;
   int unsigned result_count = 0;
   bit          no_idle      = 1'b0;

   step_row_type directed_steps [DIRECTED_COUNT] = '{
      // after reset: masked reads, open bus, unmapped access
      '{KIND_READ,     ADDR_DUTY, 8'h00, 1'b1, 8'h3F, 4'd0, 1'b0},
      '{KIND_READ,     ADDR_ENV,  8'h00, 1'b1, 8'h00, 4'd0, 1'b0},
      '{KIND_READ,     ADDR_PLOW, 8'h00, 1'b1, 8'hFF, 4'd0, 1'b0},
      '{KIND_READ,     ADDR_CTRL, 8'h00, 1'b1, 8'hBF, 4'd0, 1'b0},
      '{KIND_READ,     16'h0000,  8'h00, 1'b1, 8'hFF, 4'd0, 1'b0},
      '{KIND_WRITE,    16'hFFFF,  8'hFF, 1'b1, 8'hFF, 4'd0, 1'b0},
      // idle timer, zero envelope period, length disabled: all no-ops
      '{KIND_FREQ,     16'h0000,  8'h00, 1'b1, 8'hFF, 4'd0, 1'b0},
      '{KIND_ENVELOPE, 16'h0000,  8'h00, 1'b1, 8'hFF, 4'd0, 1'b0},
      '{KIND_LENGTH,   16'h0000,  8'h00, 1'b1, 8'hFF, 4'd0, 1'b0},
      // DAC off, then a trigger that must leave the channel silent
      '{KIND_WRITE,    ADDR_ENV,  8'h00, 1'b1, 8'hFF, 4'd0, 1'b0},
      '{KIND_WRITE,    ADDR_CTRL, 8'h80, 1'b1, 8'hFF, 4'd0, 1'b0},
      // full volume, decreasing, period 3; duty 3 with one length step left
      '{KIND_WRITE,    ADDR_ENV,  8'hF3, 1'b0, 8'h00, 4'd0, 1'b0},
      '{KIND_WRITE,    ADDR_DUTY, 8'hFF, 1'b0, 8'h00, 4'd0, 1'b0},
      '{KIND_WRITE,    ADDR_PLOW, 8'hFF, 1'b0, 8'h00, 4'd0, 1'b0},
      '{KIND_WRITE,    ADDR_CTRL, 8'hC7, 1'b0, 8'h00, 4'd0, 1'b0},
      // highest period: the timer reloads at four, so the fourth tick steps
      '{KIND_FREQ,     16'hFFFF,  8'hFF, 1'b0, 8'h00, 4'd0, 1'b0},
      '{KIND_FREQ,     16'h0000,  8'h00, 1'b0, 8'h00, 4'd0, 1'b0},
      '{KIND_FREQ,     16'h0000,  8'h00, 1'b0, 8'h00, 4'd0, 1'b0},
      '{KIND_FREQ,     16'h0000,  8'h00, 1'b0, 8'h00, 4'd0, 1'b0},
      '{KIND_ENVELOPE, 16'h0000,  8'h00, 1'b0, 8'h00, 4'd0, 1'b0},
      '{KIND_READ,     ADDR_CTRL, 8'h00, 1'b0, 8'h00, 4'd0, 1'b0},
      // length runs out and silences the channel
      '{KIND_LENGTH,   16'h0000,  8'h00, 1'b0, 8'h00, 4'd0, 1'b0},
      '{KIND_CLEAR,    16'hFFFF,  8'hFF, 1'b1, 8'hFF, 4'd0, 1'b0},
      '{KIND_SPARE_A,  ADDR_DUTY, 8'hFF, 1'b1, 8'hFF, 4'd0, 1'b0},
      '{KIND_SPARE_B,  ADDR_CTRL, 8'hFF, 1'b1, 8'hFF, 4'd0, 1'b0}
   };

   square_wave_sound_channel_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_address      (req_address),
      .req_write_data   (req_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_read_data    (rsp_read_data),
      .rsp_sample_level (rsp_sample_level),
      .rsp_channel_on   (rsp_channel_on),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Hard stop well beyond the slowest legal run (about 1250 items, plus reset).
   initial begin
      #5_000_000;
      $display("square_wave_sound_channel_top_tb NOT OK");
      $finish;
   end

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      error_count++;
      $display("result %0d: %s got %0h, expected %0h", result_count, what, got, want);
   endtask

   // Wipe the shadow channel; the duty word is left alone, as in the block.
   task automatic clear_shadow();
      duty_len_q = 8'h00;
      env_q      = 8'h00;
      plow_q     = 8'h00;
      ctrl_q     = 8'h00;
      ch_active  = 1'b0;
      len_left   = 7'd0;
      env_left   = 3'd0;
      volume     = 4'd0;
      period     = 11'd0;
      tone_timer = 14'd0;
      wave_pos   = 3'd0;
   endtask

   function automatic logic [13:0] tone_reload(input logic [10:0] p);
      logic [13:0] span;
      span = 14'd2048 - {3'b000, p};
      return span << 2;
   endfunction

   // Apply one request to the shadow channel and work out its result.
   task automatic predict_result(input item_type it, output result_type r);
      logic [7:0] rd;
      logic [7:0] d;
      logic [2:0] per;
      rd = OPEN_BUS;
      d  = it.write_data;
      case (it.kind)
         KIND_READ: begin
            case (it.address)
               ADDR_DUTY: rd = duty_len_q | DUTY_READ_MASK;
               ADDR_ENV:  rd = env_q;
               ADDR_CTRL: rd = ctrl_q | CTRL_READ_MASK;
               default:   rd = OPEN_BUS;
            endcase
         end
         KIND_WRITE: begin
            case (it.address)
               ADDR_DUTY: begin
                  duty_len_q = d;
                  len_left   = LENGTH_FULL - {1'b0, d[5:0]};
               end
               ADDR_ENV: begin
                  env_q = d;
                  // DAC off drops the channel at once
                  if (d[7:3] == 5'd0) ch_active = 1'b0;
               end
               ADDR_PLOW: plow_q = d;
               ADDR_CTRL: begin
                  ctrl_q = d;
                  if (d[7]) begin
                     if (env_q[7:3] != 5'd0) ch_active = 1'b1;
                     if (len_left == 7'd0) len_left = LENGTH_FULL;
                     env_left   = env_q[2:0];
                     volume     = env_q[7:4];
                     period     = {d[2:0], plow_q};
                     tone_timer = tone_reload(period);
                     wave_pos   = 3'd0;
                  end
               end
               default: ;
            endcase
         end
         KIND_FREQ: begin
            if (tone_timer != 14'd0) begin
               tone_timer = tone_timer - 14'd1;
               if (tone_timer == 14'd0) begin
                  tone_timer = tone_reload(period);
                  wave_pos   = wave_pos + 3'd1;
               end
            end
         end
         KIND_LENGTH: begin
            if (ctrl_q[6] && len_left != 7'd0) begin
               len_left = len_left - 7'd1;
               if (len_left == 7'd0) ch_active = 1'b0;
            end
         end
         KIND_ENVELOPE: begin
            per = env_q[2:0];
            if (per != 3'd0 && env_left != 3'd0) begin
               env_left = env_left - 3'd1;
               if (env_left == 3'd0) begin
                  env_left = per;
                  if (env_q[3]) begin
                     if (volume < VOLUME_MAX) volume = volume + 4'd1;
                  end else if (volume != 4'd0) begin
                     volume = volume - 4'd1;
                  end
               end
            end
         end
         KIND_CLEAR: clear_shadow();
         default: ;
      endcase
      r.read_data    = rd;
      r.sample_level = 4'd0;
      if (ch_active && env_q[7:3] != 5'd0 && duty_word[{duty_len_q[7:6], wave_pos}]) begin
         r.sample_level = volume;
      end
      r.channel_on = ch_active;
   endtask

   // Draw one request. Most of the mix programs the channel and ticks it, with
   // periods biased high so the duty position really moves; the rest is reads,
   // stray addresses, clears and unused codes.
   function automatic item_type random_item();
      item_type    it;
      int unsigned pick;
      it.kind       = KIND_FREQ;
      it.address    = 16'($urandom);
      it.write_data = 8'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         it.kind    = KIND_READ;
         it.address = ADDR_DUTY + 16'($urandom_range(0, 3));
      end else if (pick < 14) begin
         it.kind = KIND_READ;
      end else if (pick < 30) begin
         it.kind    = KIND_WRITE;
         it.address = ADDR_DUTY + 16'($urandom_range(0, 3));
         if (it.address == ADDR_PLOW && $urandom_range(0, 3) != 0) it.write_data[7:4] = 4'hF;
         if (it.address == ADDR_CTRL && $urandom_range(0, 3) != 0) it.write_data[2:0] = 3'h7;
      end else if (pick < 33) begin
         it.kind = KIND_WRITE;
      end else if (pick < 68) begin
         it.kind = KIND_FREQ;
      end else if (pick < 78) begin
         it.kind = KIND_LENGTH;
      end else if (pick < 90) begin
         it.kind = KIND_ENVELOPE;
      end else if (pick < 92) begin
         it.kind = KIND_CLEAR;
      end else if (pick < 94) begin
         it.kind = $urandom_range(0, 1) ? KIND_SPARE_A : KIND_SPARE_B;
      end else begin
         // trigger
         it.kind          = KIND_WRITE;
         it.address       = ADDR_CTRL;
         it.write_data[7] = 1'b1;
         if ($urandom_range(0, 3) != 0) it.write_data[2:0] = 3'h7;
      end
      return it;
   endfunction

   // Present one request after a random gap, hold it until the transfer and
   // hand back the predicted result.
   task automatic send_item(input item_type it, output result_type predicted);
      int unsigned gap;
      gap = no_idle ? 0 : $urandom_range(0, 18);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid      <= 1'b1;
      req_type       <= it.kind;
      req_address    <= it.address;
      req_write_data <= it.write_data;
      do @(posedge clock); while (!(req_valid && !req_stall));
      predict_result(it, predicted);
   endtask

   // Load a new duty word, but only once the block has drained.
   task automatic load_duty_word(input logic [31:0] word);
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= word;
      duty_word = word;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Response side: stall for a random number of cycles before each transfer.
   initial begin
      int unsigned hold;
      forever begin
         hold = no_idle ? 0 : $urandom_range(0, 18);
         repeat (hold) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
         end
         @(negedge clock);
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   // Compare every result transfer with the oldest outstanding prediction.
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         result_count++;
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result, read_data", rsp_read_data, 0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_read_data !== want.read_data)
               report_mismatch("read_data", rsp_read_data, want.read_data);
            if (rsp_sample_level !== want.sample_level)
               report_mismatch("sample_level", rsp_sample_level, want.sample_level);
            if (rsp_channel_on !== want.channel_on)
               report_mismatch("channel_on", rsp_channel_on, want.channel_on);
         end
      end
   end

   initial begin
      item_type    it;
      result_type  predicted;
      result_type  typed;
      logic [31:0] phase_words [PHASE_COUNT];
      int unsigned drain_cycles;

      duty_word = DUTY_PATTERNS_RESET;
      clear_shadow();

      // Hold reset, then release it on a falling edge.
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: walk the table with the reset duty patterns in force.
      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         it.kind       = directed_steps[i].kind;
         it.address    = directed_steps[i].address;
         it.write_data = directed_steps[i].write_data;
         send_item(it, predicted);
         if (directed_steps[i].fixed) begin
            typed.read_data    = directed_steps[i].read_data;
            typed.sample_level = directed_steps[i].sample_level;
            typed.channel_on   = directed_steps[i].channel_on;
            pending_results.push_back(typed);
         end else begin
            pending_results.push_back(predicted);
         end
      end

      // Random part: several duty settings, extremes first; two phases run
      // with no gaps on either side to keep the pipeline full.
      phase_words[0] = 32'h0000_0000;
      phase_words[1] = 32'hFFFF_FFFF;
      phase_words[2] = $urandom;
      phase_words[3] = DUTY_PATTERNS_RESET;
      phase_words[4] = $urandom;
      phase_words[5] = $urandom;
      for (int p = 0; p < PHASE_COUNT; p++) begin
         load_duty_word(phase_words[p]);
         no_idle = (p == 2 || p == 4);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            it = random_item();
            send_item(it, predicted);
            pending_results.push_back(predicted);
         end
      end

      // Drop valid, drain what is outstanding, then allow for the latency.
      @(negedge clock);
      req_valid <= 1'b0;
      no_idle = 1'b0;
      drain_cycles = 0;
      while (pending_results.size() != 0 && drain_cycles < 2000) begin
         @(posedge clock);
         drain_cycles++;
      end
      if (pending_results.size() != 0) begin
         report_mismatch("results never delivered", pending_results.size(), 0);
      end
      repeat (10) @(posedge clock);

      if (error_count == 0) begin
         $display("square_wave_sound_channel_top_tb OK");
      end else begin
         $display("square_wave_sound_channel_top_tb NOT OK");
      end
      $finish;
   end

endmodule

FILE: files.f
design/sqch_pkg.sv
design/sqch_channel.sv
design/square_wave_sound_channel_top.sv
tb/sv/square_wave_sound_channel_top_tb.sv
